// ===== hdl/lsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared widths, register map, configuration struct and constant tables of
// the laser scan rasterizer.
// ----------------------------------------------------------------------------
package lsr_pkg;

	localparam int MAX_IMAGE_DIM = 4096;
	localparam int MAX_SAMPLES   = 4096;

	localparam int RANGE_W    = 16;
	localparam int IDX_W      = $clog2(MAX_SAMPLES);
	localparam int ANG_W      = 16;
	localparam int DIM_W      = $clog2(MAX_IMAGE_DIM) + 1;
	localparam int PIX_W      = $clog2(MAX_IMAGE_DIM);
	localparam int SCALE_W    = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 18;
	localparam int TRIG_W       = 15;
	localparam int ATAN_W       = 14;
	localparam int CORDIC_X0    = 19899;
	localparam int Q15_MAX      = 32767;

	// scaling datapath
	localparam int PROD_W  = RANGE_W + TRIG_W;
	localparam int FULL_W  = PROD_W + SCALE_W;
	localparam int SHIFT   = 31;
	localparam int AMAG_W  = FULL_W - SHIFT;
	localparam int POS_W   = AMAG_W + 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE    = 4'd0,
		REG_MAX_RANGE    = 4'd1,
		REG_START_ANGLE  = 4'd2,
		REG_ANGLE_STEP   = 4'd3,
		REG_IMAGE_WIDTH  = 4'd4,
		REG_IMAGE_HEIGHT = 4'd5,
		REG_X_SCALE      = 4'd6,
		REG_Y_SCALE      = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RANGE_W-1:0]      min_range;
		logic [RANGE_W-1:0]      upper_range;
		logic signed [ANG_W-1:0] start_angle;
		logic signed [ANG_W-1:0] angle_step;
		logic [DIM_W-1:0]        image_width;
		logic [DIM_W-1:0]        image_height;
		logic [SCALE_W-1:0]      x_scale;
		logic [SCALE_W-1:0]      y_scale;
	} cfg_t;

	// one classified sample between front and back
	typedef struct packed {
		logic               ok;
		logic [RANGE_W-1:0] range;
		logic [ANG_W-1:0]   ang;
	} qent_t;

	// rounded atan(2^-k) in binary angle units
	function automatic logic [ATAN_W-1:0] atan_unit(input int k);
		logic [ATAN_W-1:0] v;
		case (k)
			0:       v = 14'd8192;
			1:       v = 14'd4836;
			2:       v = 14'd2555;
			3:       v = 14'd1297;
			4:       v = 14'd651;
			5:       v = 14'd326;
			6:       v = 14'd163;
			7:       v = 14'd81;
			8:       v = 14'd41;
			9:       v = 14'd20;
			10:      v = 14'd10;
			11:      v = 14'd5;
			12:      v = 14'd3;
			13:      v = 14'd1;
			14:      v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : d;
	endfunction

endpackage

// ===== hdl/lsr_if.sv =====
// ----------------------------------------------------------------------------
// lsr_if
// Valid/ready channels of the laser scan rasterizer: sample in, pixel out,
// register write.
// ----------------------------------------------------------------------------
interface lsr_in_if import lsr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RANGE_W-1:0] range_mm;
	logic [IDX_W-1:0]   sample_index;

	modport source (output valid, output range_mm, output sample_index, input ready);
	modport sink   (input valid, input range_mm, input sample_index, output ready);
endinterface

interface lsr_out_if import lsr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic             hit;

	modport source (output valid, output pixel_x, output pixel_y, output hit, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input hit, output ready);
endinterface

interface lsr_cfg_if import lsr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lsr_regs.sv =====
// ----------------------------------------------------------------------------
// lsr_regs
// Configuration register file, written over the register channel.
// ----------------------------------------------------------------------------
module lsr_regs import lsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lsr_cfg_if.sink   cfg_ch,
	output cfg_t      cfg
);

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_range    <= '0;
			cfg_q.upper_range  <= RANGE_W'(65535);
			cfg_q.start_angle  <= '0;
			cfg_q.angle_step   <= '0;
			cfg_q.image_width  <= DIM_W'(512);
			cfg_q.image_height <= DIM_W'(512);
			cfg_q.x_scale      <= '0;
			cfg_q.y_scale      <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_MIN_RANGE:    cfg_q.min_range    <= cfg_ch.data[RANGE_W-1:0];
				REG_MAX_RANGE:    cfg_q.upper_range  <= cfg_ch.data[RANGE_W-1:0];
				REG_START_ANGLE:  cfg_q.start_angle  <= cfg_ch.data[ANG_W-1:0];
				REG_ANGLE_STEP:   cfg_q.angle_step   <= cfg_ch.data[ANG_W-1:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_ch.data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_ch.data[DIM_W-1:0];
				REG_X_SCALE:      cfg_q.x_scale      <= cfg_ch.data[SCALE_W-1:0];
				REG_Y_SCALE:      cfg_q.y_scale      <= cfg_ch.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/lsr_front.sv =====
// ----------------------------------------------------------------------------
// lsr_front
// Accepts samples, forms the beam angle and classifies the range.
// ----------------------------------------------------------------------------
module lsr_front import lsr_pkg::*; (
	lsr_in_if.sink    in_ch,
	input  cfg_t      cfg,
	input  logic      q_full,
	output logic      q_push,
	output qent_t     q_wdata
);

	logic [IDX_W+ANG_W-1:0] ang_prod;

	assign in_ch.ready = !q_full;
	assign q_push      = in_ch.valid && !q_full;

	// low bits of the product are the same for signed and unsigned step
	assign ang_prod = (IDX_W+ANG_W)'(in_ch.sample_index)
		* (IDX_W+ANG_W)'(unsigned'(cfg.angle_step));

	always_comb begin
		q_wdata.range = in_ch.range_mm;
		q_wdata.ang   = unsigned'(cfg.start_angle) + ang_prod[ANG_W-1:0];
		// sample_index cannot reach MAX_SAMPLES at its width
		q_wdata.ok    = (in_ch.range_mm > cfg.min_range) && (in_ch.range_mm < cfg.upper_range);
	end

endmodule

// ===== hdl/lsr_queue.sv =====
// ----------------------------------------------------------------------------
// lsr_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module lsr_queue import lsr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  nempty,
	output qent_t rdata
);

	qent_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full   = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/lsr_back.sv =====
// ----------------------------------------------------------------------------
// lsr_back
// Pipelined CORDIC rotation, per-axis scaling, centering and image bound
// check. The whole pipeline advances when the output register is free.
// ----------------------------------------------------------------------------
module lsr_back import lsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_nempty,
	input  qent_t      q_rdata,
	output logic       q_pop,
	lsr_out_if.source  out_ch
);

	localparam int NSTG = CORDIC_STEPS + 6;
	localparam int S_RES  = CORDIC_STEPS + 5;

	typedef struct packed {
		logic                 ok;
		logic                 flip;
		logic [RANGE_W-1:0]   range;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cor_t;

	typedef struct packed {
		logic               ok;
		logic [RANGE_W-1:0] range;
		logic               xneg;
		logic               yneg;
		logic [TRIG_W-1:0]  xmag;
		logic [TRIG_W-1:0]  ymag;
	} trig_t;

	function automatic logic signed [CW-1:0] sat_q15(input logic signed [CW-1:0] v);
		if (v > CW'(Q15_MAX))
			return CW'(Q15_MAX);
		if (v < -CW'(Q15_MAX))
			return -CW'(Q15_MAX);
		return v;
	endfunction

	logic        vld_s [NSTG];
	logic        adv;
	cor_t        cor_s [CORDIC_STEPS+1];
	cor_t        entry;
	trig_t       trig_s17;
	trig_t       trig_d;
	logic        ok_s18, xneg_s18, yneg_s18;
	logic [PROD_W-1:0] xprod_s18, yprod_s18;
	logic        ok_s19, xneg_s19, yneg_s19;
	logic [AMAG_W-1:0] xamag_s19, yamag_s19;
	logic [FULL_W-1:0] xfull, yfull;
	logic        ok_s20;
	logic [POS_W-1:0]  xpos_s20, ypos_s20;
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [PIX_W-1:0]  px_s21, py_s21;
	logic        hit_s21;
	logic        hit_d;

	assign adv   = !vld_s[S_RES] || out_ch.ready;
	assign q_pop = adv && q_nempty;

	assign w_eff = clamp_dim(cfg.image_width);
	assign h_eff = clamp_dim(cfg.image_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= q_nempty;
			for (int i = 1; i < NSTG; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// quadrant fold: angles in the left half plane turn by half a circle
	always_comb begin
		entry.ok    = q_rdata.ok;
		entry.range = q_rdata.range;
		entry.flip  = q_rdata.ang[ANG_W-1] ^ q_rdata.ang[ANG_W-2];
		entry.x     = CW'(CORDIC_X0);
		entry.y     = '0;
		entry.z     = CW'(signed'({q_rdata.ang[ANG_W-1] ^ entry.flip, q_rdata.ang[ANG_W-2:0]}));
	end

	always_ff @(posedge clk) begin
		if (adv)
			cor_s[0] <= entry;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		logic signed [CW-1:0] dx, dy;
		logic signed [CW-1:0] at;
		cor_t nxt;

		assign dx = cor_s[k].y >>> k;
		assign dy = cor_s[k].x >>> k;
		assign at = CW'(atan_unit(k));

		always_comb begin
			nxt = cor_s[k];
			if (!cor_s[k].z[CW-1]) begin
				nxt.x = cor_s[k].x - dx;
				nxt.y = cor_s[k].y + dy;
				nxt.z = cor_s[k].z - at;
			end else begin
				nxt.x = cor_s[k].x + dx;
				nxt.y = cor_s[k].y - dy;
				nxt.z = cor_s[k].z + at;
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				cor_s[k+1] <= nxt;
		end
	end

	// saturate, apply the fold and split into sign and magnitude
	always_comb begin
		logic signed [CW-1:0] xs, ys, xa, ya;
		xs = sat_q15(cor_s[CORDIC_STEPS].x);
		ys = sat_q15(cor_s[CORDIC_STEPS].y);
		xa = xs[CW-1] ? -xs : xs;
		ya = ys[CW-1] ? -ys : ys;
		trig_d.ok    = cor_s[CORDIC_STEPS].ok;
		trig_d.range = cor_s[CORDIC_STEPS].range;
		trig_d.xneg  = xs[CW-1] ^ cor_s[CORDIC_STEPS].flip;
		trig_d.yneg  = ys[CW-1] ^ cor_s[CORDIC_STEPS].flip;
		trig_d.xmag  = xa[TRIG_W-1:0];
		trig_d.ymag  = ya[TRIG_W-1:0];
	end

	assign xfull = FULL_W'(xprod_s18) * FULL_W'(cfg.x_scale);
	assign yfull = FULL_W'(yprod_s18) * FULL_W'(cfg.y_scale);

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s17 <= trig_d;

			ok_s18    <= trig_s17.ok;
			xneg_s18  <= trig_s17.xneg;
			yneg_s18  <= trig_s17.yneg;
			xprod_s18 <= PROD_W'(trig_s17.range) * PROD_W'(trig_s17.xmag);
			yprod_s18 <= PROD_W'(trig_s17.range) * PROD_W'(trig_s17.ymag);

			// magnitude >> 31 truncates toward zero once the sign is restored
			ok_s19    <= ok_s18;
			xneg_s19  <= xneg_s18;
			yneg_s19  <= yneg_s18;
			xamag_s19 <= xfull[FULL_W-1:SHIFT];
			yamag_s19 <= yfull[FULL_W-1:SHIFT];

			ok_s20   <= ok_s19;
			xpos_s20 <= xneg_s19 ? POS_W'(w_eff >> 1) - POS_W'(xamag_s19)
			                     : POS_W'(w_eff >> 1) + POS_W'(xamag_s19);
			ypos_s20 <= yneg_s19 ? POS_W'(h_eff >> 1) - POS_W'(yamag_s19)
			                     : POS_W'(h_eff >> 1) + POS_W'(yamag_s19);

			hit_s21 <= hit_d;
			px_s21  <= hit_d ? xpos_s20[PIX_W-1:0] : '0;
			py_s21  <= hit_d ? ypos_s20[PIX_W-1:0] : '0;
		end
	end

	assign hit_d = ok_s20
		&& !xpos_s20[POS_W-1] && (xpos_s20[POS_W-2:0] < (POS_W-1)'(w_eff))
		&& !ypos_s20[POS_W-1] && (ypos_s20[POS_W-2:0] < (POS_W-1)'(h_eff));

	assign out_ch.valid   = vld_s[S_RES];
	assign out_ch.pixel_x = px_s21;
	assign out_ch.pixel_y = py_s21;
	assign out_ch.hit     = hit_s21;

endmodule

// ===== hdl/laser_scan_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// laser_scan_rasterizer_top
// Maps one lidar range sample to a pixel of a scan image centered on the
// sensor.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// result beat per sample, in order. Each sample passes the queue write, the
// fold, a 16-stage CORDIC, saturation, two multiply stages, centering and
// bound check. A 4-entry queue after the classifier absorbs input while the
// output stalls; the back pipeline holds as a whole whenever its output
// register is full and not taken. Rejected ranges and pixels off the image
// still produce a beat, with hit low and zero coords. The user must write
// registers only while no sample is in flight; the block does not enforce it.
module laser_scan_rasterizer_top import lsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lsr_in_if.sink    in_ch,
	lsr_out_if.source out_ch,
	lsr_cfg_if.sink   cfg_ch
);

	cfg_t  cfg;
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_nempty;
	qent_t q_wdata;
	qent_t q_rdata;

	lsr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	lsr_front u_front (
		.in_ch   (in_ch),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	lsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_rdata)
	);

	lsr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_nempty (q_nempty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.out_ch   (out_ch)
	);

endmodule

// ===== verif/laser_scan_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// laser_scan_rasterizer_top_tb
// Self-checking bench for the lidar sample to pixel rasterizer. A bit-exact
// CORDIC and scaling predictor computes the pixel of every accepted sample,
// and a monitor checks the result beats in order. The run starts with
// directed samples on the range limits, the quadrant folds and the image
// bounds. Random scans follow under several register settings, with random
// gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module laser_scan_rasterizer_top_tb import lsr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 23;
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int SCAN_SEGS    = 6;
	localparam int SEG_SAMPLES  = 142;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 4'hF;

	// rounded atan(2^-k), binary angle units
	localparam int ATAN_BAM [CORDIC_STEPS] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic [IDX_W-1:0]   idx;
	} beam_t;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             hit;
	} pix_t;

	logic clk;
	logic arst_n;

	lsr_in_if  in_ch ();
	lsr_out_if out_ch ();
	lsr_cfg_if cfg_ch ();

	laser_scan_rasterizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	beam_t pending_beams [$];
	pix_t  expected_pixels [$];
	cfg_t  live_cfg;

	int sender_idle_pct;
	int sink_idle_pct;
	int accepted_count;
	int hold_from;
	int hold_left;
	bit hold_used;
	int mismatches;
	int beats_seen;
	int hits_seen;
	int settings_count;
	int cycles;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ---------------- predictor ----------------

	function automatic void beam_trig(input logic [ANG_W-1:0] ang, output int c, output int s);
		logic [ANG_W-1:0] a;
		bit flip;
		int x, y, z, dx, dy;
		a = ang;
		flip = 1'b0;
		// fold the left half plane onto the right one, negate at the end
		if (a >= 16'h4000 && a < 16'hC000) begin
			a = a - 16'h8000;
			flip = 1'b1;
		end
		x = CORDIC_X0;
		y = 0;
		z = int'(signed'(a));
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_BAM[k];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_BAM[k];
			end
		end
		if (x > Q15_MAX) x = Q15_MAX;
		if (x < -Q15_MAX) x = -Q15_MAX;
		if (y > Q15_MAX) y = Q15_MAX;
		if (y < -Q15_MAX) y = -Q15_MAX;
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// range * trig * Q8.16 scale, truncated toward zero, plus half the size
	function automatic longint axis_pixel(input logic [RANGE_W-1:0] r, input int trig,
			input logic [SCALE_W-1:0] scale, input logic [DIM_W-1:0] size);
		longint unsigned mag;
		longint q;
		mag = 64'(r) * 64'(trig < 0 ? -trig : trig);
		mag = (mag * 64'(scale)) >> 31;
		q = longint'(mag);
		if (trig < 0) q = -q;
		return q + longint'(size / 2);
	endfunction

	function automatic pix_t predict_pixel(input beam_t b);
		pix_t r;
		logic [ANG_W-1:0] ang;
		logic [DIM_W-1:0] w, h;
		int c, s;
		longint px, py;
		r = '0;
		w = (live_cfg.image_width > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : live_cfg.image_width;
		h = (live_cfg.image_height > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : live_cfg.image_height;
		if (b.range <= live_cfg.min_range || b.range >= live_cfg.upper_range)
			return r;
		ang = ANG_W'(32'(live_cfg.start_angle) + 32'(b.idx) * 32'(live_cfg.angle_step));
		beam_trig(ang, c, s);
		px = axis_pixel(b.range, c, live_cfg.x_scale, w);
		py = axis_pixel(b.range, s, live_cfg.y_scale, h);
		if (px >= 0 && px < longint'(w) && py >= 0 && py < longint'(h)) begin
			r.x = PIX_W'(px);
			r.y = PIX_W'(py);
			r.hit = 1'b1;
		end
		return r;
	endfunction

	// ---------------- sample driver ----------------

	always @(posedge clk or negedge arst_n) begin : sample_driver
		beam_t b;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.range_mm <= '0;
			in_ch.sample_index <= '0;
			accepted_count <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				b.range = in_ch.range_mm;
				b.idx = in_ch.sample_index;
				expected_pixels = {expected_pixels, predict_pixel(b)};
				accepted_count <= accepted_count + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_beams.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					b = pending_beams.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.range_mm <= b.range;
					in_ch.sample_index <= b.idx;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result sink ----------------

	always @(posedge clk or negedge arst_n) begin : result_ready
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_used && accepted_count >= hold_from) begin
			// long back-pressure: the queue fills and the input stalls
			out_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : pixel_check
		pix_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			beats_seen++;
			if (out_ch.hit) hits_seen++;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result beat: pixel_x %0d pixel_y %0d hit %0b",
					out_ch.pixel_x, out_ch.pixel_y, out_ch.hit);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_ch.pixel_x !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", want.x, out_ch.pixel_x);
					mismatches++;
				end
				if (out_ch.pixel_y !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", want.y, out_ch.pixel_y);
					mismatches++;
				end
				if (out_ch.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, out_ch.hit);
					mismatches++;
				end
			end
		end
	end

	// ---------------- register writes ----------------

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= wdata;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MIN_RANGE:    live_cfg.min_range = wdata[RANGE_W-1:0];
			REG_MAX_RANGE:    live_cfg.upper_range = wdata[RANGE_W-1:0];
			REG_START_ANGLE:  live_cfg.start_angle = wdata[ANG_W-1:0];
			REG_ANGLE_STEP:   live_cfg.angle_step = wdata[ANG_W-1:0];
			REG_IMAGE_WIDTH:  live_cfg.image_width = wdata[DIM_W-1:0];
			REG_IMAGE_HEIGHT: live_cfg.image_height = wdata[DIM_W-1:0];
			REG_X_SCALE:      live_cfg.x_scale = wdata[SCALE_W-1:0];
			REG_Y_SCALE:      live_cfg.y_scale = wdata[SCALE_W-1:0];
			default:          ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_all(input cfg_t c);
		write_reg(REG_MIN_RANGE, CFG_DATA_W'(c.min_range));
		write_reg(REG_MAX_RANGE, CFG_DATA_W'(c.upper_range));
		write_reg(REG_START_ANGLE, CFG_DATA_W'(c.start_angle));
		write_reg(REG_ANGLE_STEP, CFG_DATA_W'(c.angle_step));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
		write_reg(REG_X_SCALE, CFG_DATA_W'(c.x_scale));
		write_reg(REG_Y_SCALE, CFG_DATA_W'(c.y_scale));
		settings_count++;
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_beams.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
	endtask

	task automatic push_beam(input int range, input int idx);
		beam_t b;
		b.range = RANGE_W'(range);
		b.idx = IDX_W'(idx);
		pending_beams = {pending_beams, b};
	endtask

	// scale that maps twice the max range onto the image, give or take 15%
	function automatic logic [SCALE_W-1:0] fit_scale(input int size, input int max_r);
		longint unsigned f;
		f = (64'(size) * 65536 * 64'($urandom_range(85, 115))) / (64'(max_r) * 200);
		return (f > 64'hFF_FFFF) ? SCALE_W'(24'hFF_FFFF) : SCALE_W'(f);
	endfunction

	function automatic cfg_t random_setup();
		cfg_t c;
		c.upper_range = RANGE_W'($urandom_range(500, 65535));
		c.min_range = RANGE_W'($urandom_range(0, c.upper_range / 4));
		c.start_angle = ANG_W'($urandom);
		if ($urandom_range(1))
			c.angle_step = ANG_W'($urandom);
		else
			c.angle_step = ANG_W'(65536 / $urandom_range(16, 4096));
		c.image_width = DIM_W'($urandom_range(16, MAX_IMAGE_DIM));
		c.image_height = DIM_W'($urandom_range(16, MAX_IMAGE_DIM));
		c.x_scale = fit_scale(c.image_width, c.upper_range);
		c.y_scale = fit_scale(c.image_height, c.upper_range);
		return c;
	endfunction

	// mostly in-window ranges, the rest anywhere or right on the limits
	task automatic queue_scan(input cfg_t c, input int count);
		int r;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(7))
				0:       r = $urandom_range(0, 65535);
				1:       r = ($urandom_range(1)) ? c.min_range : c.upper_range;
				2:       r = ($urandom_range(1)) ? 0 : 65535;
				default: begin
					if (c.upper_range > c.min_range + 1)
						r = $urandom_range(c.min_range + 1, c.upper_range - 1);
					else
						r = $urandom_range(0, 65535);
				end
			endcase
			push_beam(r, $urandom_range(0, MAX_SAMPLES - 1));
		end
	endtask

	// ---------------- sequence ----------------

	initial begin : run_sequence
		cfg_t setup;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		hold_from = 32'h7FFF_FFFF;
		sender_idle_pct = 30;
		sink_idle_pct = 68;
		live_cfg.min_range = '0;
		live_cfg.upper_range = 16'hFFFF;
		live_cfg.start_angle = '0;
		live_cfg.angle_step = '0;
		live_cfg.image_width = DIM_W'(512);
		live_cfg.image_height = DIM_W'(512);
		live_cfg.x_scale = '0;
		live_cfg.y_scale = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// quarter-turn steps: fold boundaries and range window limits
		setup.min_range = 16'd100;
		setup.upper_range = 16'd60000;
		setup.start_angle = '0;
		setup.angle_step = 16'h4000;
		setup.image_width = DIM_W'(512);
		setup.image_height = DIM_W'(512);
		setup.x_scale = SCALE_W'(279);
		setup.y_scale = SCALE_W'(279);
		program_all(setup);
		push_beam(50, 0);
		push_beam(100, 0);
		push_beam(60000, 0);
		push_beam(101, 0);
		push_beam(59999, 0);
		push_beam(30000, 1);
		push_beam(30000, 2);
		push_beam(30000, 3);
		push_beam(30000, 4095);
		push_beam(0, 0);
		push_beam(65535, 0);
		wait_drained();

		// zero width, oversize height, full-scale x: nothing lands on the image
		setup.min_range = '0;
		setup.upper_range = 16'hFFFF;
		setup.start_angle = 16'h3FFF;
		setup.angle_step = 16'h8000;
		setup.image_width = '0;
		setup.image_height = DIM_W'(8191);
		setup.x_scale = 24'hFF_FFFF;
		setup.y_scale = '0;
		program_all(setup);
		push_beam(1000, 0);
		push_beam(1000, 1);
		push_beam(65534, 4095);
		push_beam(1, 2);
		wait_drained();

		// oversize width clamps to the maximum; a write to an unused index
		setup.start_angle = 16'h2000;
		setup.angle_step = 16'h0100;
		setup.image_width = DIM_W'(8191);
		setup.image_height = DIM_W'(MAX_IMAGE_DIM);
		setup.x_scale = SCALE_W'(2048);
		setup.y_scale = SCALE_W'(2048);
		program_all(setup);
		write_reg(UNUSED_REG_INDEX, 24'hFF_FFFF);
		push_beam(65534, 0);
		push_beam(40000, 10);
		push_beam(1, 4095);
		wait_drained();

		for (int seg = 0; seg < SCAN_SEGS; seg++) begin
			if (seg < 2) begin
				sender_idle_pct = 30;
				sink_idle_pct = 68;
			end else if (seg < 4) begin
				sender_idle_pct = 68;
				sink_idle_pct = 30;
			end else begin
				sender_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (seg == 1) begin
				// full-scale factors: only very short ranges stay on the image
				setup.min_range = '0;
				setup.upper_range = 16'hFFFF;
				setup.start_angle = 16'h8000;
				setup.angle_step = 16'h7FFF;
				setup.image_width = DIM_W'(MAX_IMAGE_DIM);
				setup.image_height = DIM_W'(MAX_IMAGE_DIM);
				setup.x_scale = 24'hFF_FFFF;
				setup.y_scale = 24'hFF_FFFF;
			end else if (seg == 3) begin
				// one-pixel-wide image, x collapsed onto column zero
				setup.min_range = '0;
				setup.upper_range = 16'hFFFF;
				setup.start_angle = 16'h7FFF;
				setup.angle_step = 16'h8000;
				setup.image_width = DIM_W'(1);
				setup.image_height = DIM_W'(8191);
				setup.x_scale = '0;
				setup.y_scale = fit_scale(MAX_IMAGE_DIM, 65535);
			end else begin
				setup = random_setup();
			end
			program_all(setup);
			if (seg == 4)
				hold_from = accepted_count + 20;
			queue_scan(setup, SEG_SAMPLES);
			wait_drained();
		end

		repeat (2 * PIPE_LATENCY) @(posedge clk);
		$display("Covered %0d samples under %0d register settings.", accepted_count,
			settings_count);
		$display("Checked %0d result beats, %0d of them pixel hits.", beats_seen, hits_seen);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding.", cycles,
			expected_pixels.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== laser_scan_rasterizer_top.f =====
hdl/lsr_pkg.sv
hdl/lsr_if.sv
hdl/lsr_regs.sv
hdl/lsr_front.sv
hdl/lsr_queue.sv
hdl/lsr_back.sv
hdl/laser_scan_rasterizer_top.sv
verif/laser_scan_rasterizer_top_tb.sv
